// ===== hw/rtl/sstf_disk_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// sstf_disk_scheduler_assert.svh
// Assertion macros for the SSTF disk scheduler; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef SSTF_DISK_SCHEDULER_ASSERT_SVH
`define SSTF_DISK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define SSTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SSTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSTF_ASSERT_IMP(lbl, ante, cons, msg)
`define SSTF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/sstf_pkg.sv =====
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared widths and types of the SSTF disk scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int PORT_TRACK_W = 16;
  localparam int SEEK_W       = 16;
  localparam int SUM_W        = 23;
  localparam int TOTAL_W      = 22;

  typedef struct packed {
    logic store;
    logic last;
    logic ovf;
  } req_flags_t;

endpackage

// ===== hw/rtl/sstf_disk_scheduler.sv =====
// ----------------------------------------------------------------------------
// sstf_disk_scheduler
// Shortest-seek-time-first scheduler over a batch of track requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/busy: a beat is taken at an edge with start high
//   and busy low. Beats go into a four-entry queue; the scheduler drains it
//   into the request RAM at one beat per cycle while idle, so loading runs
//   at one request per cycle. A beat with last_request set closes the
//   batch and starts scheduling; up to MAX_QUEUE requests are kept, later
//   ones are dropped and reported through dropped.
//   Each round reads every stored request once from the RAM. While a batch
//   is scheduled the queue fills and busy rises after four beats.
//   Results appear on result_valid for one cycle each, in service order,
//   never in two adjacent cycles; the receiver cannot stall them.
//   start_track is written over cfg_valid/cfg_ready; the user must write it
//   only while idle, the block itself does not enforce this. cfg_ready is
//   always high. Reset empties the queue and the batch, clears the served
//   marks and sets start_track to zero.
// ----------------------------------------------------------------------------
`include "sstf_disk_scheduler_assert.svh"

module sstf_disk_scheduler import sstf_pkg::*; #(
  parameter int MAX_QUEUE  = 64,
  parameter int TRACK_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [PORT_TRACK_W-1:0] request_track,
  input  logic                    last_request,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [PORT_TRACK_W-1:0] cfg_data,
  output logic                    result_valid,
  output logic [PORT_TRACK_W-1:0] served_track,
  output logic [SEEK_W-1:0]       seek_distance,
  output logic [TOTAL_W-1:0]      total_movement,
  output logic                    last_served,
  output logic                    dropped
);

  localparam int IDX_W   = $clog2(MAX_QUEUE);
  localparam int CNT_W   = $clog2(MAX_QUEUE + 1);
  localparam int Q_DEPTH = 4;
  localparam int Q_W     = TRACK_BITS + IDX_W + CNT_W + $bits(req_flags_t);

  logic [PORT_TRACK_W-1:0] start_track;

  logic                  q_push;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [Q_W-1:0]        q_din;
  logic [Q_W-1:0]        q_dout;
  logic [TRACK_BITS-1:0] f_track;
  logic [IDX_W-1:0]      f_slot;
  logic [CNT_W-1:0]      f_count;
  req_flags_t            f_flags;
  logic [TRACK_BITS-1:0] q_track;
  logic [IDX_W-1:0]      q_slot;
  logic [CNT_W-1:0]      q_count;
  req_flags_t            q_flags;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_track <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_track <= cfg_data;
    end
  end

  sstf_front #(
    .MAX_QUEUE  (MAX_QUEUE),
    .TRACK_BITS (TRACK_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .q_full        (q_full),
    .request_track (request_track),
    .last_request  (last_request),
    .push          (q_push),
    .push_track    (f_track),
    .push_slot     (f_slot),
    .push_count    (f_count),
    .push_flags    (f_flags)
  );

  assign q_din = {f_track, f_slot, f_count, f_flags};

  sstf_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid),
    .full  (q_full)
  );

  assign {q_track, q_slot, q_count, q_flags} = q_dout;

  sstf_back #(
    .MAX_QUEUE  (MAX_QUEUE),
    .TRACK_BITS (TRACK_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_track        (q_track),
    .q_slot         (q_slot),
    .q_count        (q_count),
    .q_flags        (q_flags),
    .q_pop          (q_pop),
    .start_track    (start_track),
    .result_valid   (result_valid),
    .served_track   (served_track),
    .seek_distance  (seek_distance),
    .total_movement (total_movement),
    .last_served    (last_served),
    .dropped        (dropped)
  );

  `SSTF_ASSERT_NXT(a_result_gap, result_valid, !result_valid, "result beats in adjacent cycles")
  `SSTF_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid, "scheduler popped an empty queue")

endmodule

// ===== hw/rtl/sstf_ram.sv =====
// ----------------------------------------------------------------------------
// sstf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sstf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/sstf_fifo.sv =====
// ----------------------------------------------------------------------------
// sstf_fifo
// Short register queue between the request front end and the scheduler.
// ----------------------------------------------------------------------------
module sstf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             valid,
  output logic             full
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign valid = (count != '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/sstf_front.sv =====
// ----------------------------------------------------------------------------
// sstf_front
// Accepts request beats, assigns store slots and flags dropped requests.
// ----------------------------------------------------------------------------
module sstf_front import sstf_pkg::*; #(
  parameter int MAX_QUEUE  = 64,
  parameter int TRACK_BITS = 16,
  localparam int IDX_W = $clog2(MAX_QUEUE),
  localparam int CNT_W = $clog2(MAX_QUEUE + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    q_full,
  input  logic [PORT_TRACK_W-1:0] request_track,
  input  logic                    last_request,
  output logic                    push,
  output logic [TRACK_BITS-1:0]   push_track,
  output logic [IDX_W-1:0]        push_slot,
  output logic [CNT_W-1:0]        push_count,
  output req_flags_t              push_flags
);

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             has_room;
  logic [TRACK_BITS+PORT_TRACK_W-1:0] track_wide;

  assign push       = start && !q_full;
  assign has_room   = (count < CNT_W'(MAX_QUEUE));
  assign track_wide = {{TRACK_BITS{1'b0}}, request_track};
  assign push_track = track_wide[TRACK_BITS-1:0];
  assign push_slot  = count[IDX_W-1:0];
  assign push_count = has_room ? count + CNT_W'(1) : count;

  always_comb begin
    push_flags.store = has_room;
    push_flags.last  = last_request;
    push_flags.ovf   = ovf || !has_room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (push) begin
      if (last_request) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= push_count;
        ovf   <= push_flags.ovf;
      end
    end
  end

endmodule

// ===== hw/rtl/sstf_back.sv =====
// ----------------------------------------------------------------------------
// sstf_back
// Stores queued requests and runs the nearest-track search for each batch.
// ----------------------------------------------------------------------------
module sstf_back import sstf_pkg::*; #(
  parameter int MAX_QUEUE  = 64,
  parameter int TRACK_BITS = 16,
  localparam int IDX_W = $clog2(MAX_QUEUE),
  localparam int CNT_W = $clog2(MAX_QUEUE + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  logic [TRACK_BITS-1:0]   q_track,
  input  logic [IDX_W-1:0]        q_slot,
  input  logic [CNT_W-1:0]        q_count,
  input  req_flags_t              q_flags,
  output logic                    q_pop,
  input  logic [PORT_TRACK_W-1:0] start_track,
  output logic                    result_valid,
  output logic [PORT_TRACK_W-1:0] served_track,
  output logic [SEEK_W-1:0]       seek_distance,
  output logic [TOTAL_W-1:0]      total_movement,
  output logic                    last_served,
  output logic                    dropped
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } back_state_t;

  back_state_t            state;
  logic [CNT_W-1:0]       n_req;
  logic                   ovf;
  logic [TRACK_BITS-1:0]  head;
  logic [SUM_W-1:0]       sum;
  logic [MAX_QUEUE-1:0]   served;
  logic [CNT_W-1:0]       round;
  logic [CNT_W-1:0]       rd_ptr;
  logic                   cmp_valid;
  logic                   cmp_last;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   found;
  logic [IDX_W-1:0]       best_idx;
  logic [TRACK_BITS-1:0]  best_track;
  logic [TRACK_BITS-1:0]  best_dist;

  logic                   wr_en;
  logic [TRACK_BITS-1:0]  rd_data;
  logic                   issue;
  logic [TRACK_BITS-1:0]  cand_dist;
  logic                   better;
  logic                   round_last;
  logic [SUM_W-1:0]       new_sum;
  logic [TRACK_BITS+SUM_W-1:0]        dist_wide;
  logic [TRACK_BITS+PORT_TRACK_W-1:0] start_wide;
  logic [TRACK_BITS+PORT_TRACK_W-1:0] track_out_wide;
  logic [TRACK_BITS+SEEK_W-1:0]       dist_out_wide;

  sstf_ram #(
    .WIDTH (TRACK_BITS),
    .DEPTH (MAX_QUEUE)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (q_slot),
    .wr_data (q_track),
    .rd_addr (rd_ptr[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    q_pop          = (state == ST_IDLE) && q_valid;
    wr_en          = q_pop && q_flags.store;
    issue          = (state == ST_SCAN) && (rd_ptr < n_req);
    cand_dist      = (head >= rd_data) ? head - rd_data : rd_data - head;
    better         = cmp_valid && !served[cmp_idx] && (!found || cand_dist < best_dist);
    round_last     = ((round + CNT_W'(1)) == n_req);
    dist_wide      = {{SUM_W{1'b0}}, best_dist};
    new_sum        = sum + dist_wide[SUM_W-1:0];
    start_wide     = {{TRACK_BITS{1'b0}}, start_track};
    track_out_wide = {{PORT_TRACK_W{1'b0}}, best_track};
    dist_out_wide  = {{SEEK_W{1'b0}}, best_dist};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      cmp_valid    <= 1'b0;
      served       <= '0;
      found        <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      cmp_valid    <= issue;
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_flags.last) begin
            served <= '0;
            found  <= 1'b0;
            state  <= (q_count == '0) ? ST_IDLE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (better) begin
            found <= 1'b1;
          end
          if (cmp_valid && cmp_last) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          result_valid     <= 1'b1;
          served[best_idx] <= 1'b1;
          found            <= 1'b0;
          state            <= round_last ? ST_IDLE : ST_SCAN;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cmp_idx  <= rd_ptr[IDX_W-1:0];
    cmp_last <= ((rd_ptr + CNT_W'(1)) == n_req);
    unique case (state)
      ST_IDLE: begin
        if (q_pop && q_flags.last) begin
          n_req  <= q_count;
          ovf    <= q_flags.ovf;
          head   <= start_wide[TRACK_BITS-1:0];
          sum    <= '0;
          round  <= '0;
          rd_ptr <= '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_ptr <= rd_ptr + CNT_W'(1);
        end
        if (better) begin
          best_idx   <= cmp_idx;
          best_track <= rd_data;
          best_dist  <= cand_dist;
        end
      end
      ST_EMIT: begin
        served_track   <= track_out_wide[PORT_TRACK_W-1:0];
        seek_distance  <= dist_out_wide[SEEK_W-1:0];
        total_movement <= new_sum[TOTAL_W-1:0];
        last_served    <= round_last;
        dropped        <= ovf;
        head           <= best_track;
        sum            <= new_sum;
        round          <= round + CNT_W'(1);
        rd_ptr         <= '0;
      end
      default: begin
        rd_ptr <= '0;
      end
    endcase
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SSTF disk scheduler. Batches of track requests
// are loaded over start/busy; a scoreboard keeps its own copy of the request
// store and start track, orders each batch by shortest seek and checks every
// served-track beat field by field. Start track is rewritten between batches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sstf_pkg::*;

  localparam int QUEUE_DEPTH    = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 70;

  typedef struct packed {
    logic [PORT_TRACK_W-1:0] served_track;
    logic [SEEK_W-1:0]       seek_distance;
    logic [TOTAL_W-1:0]      total_movement;
    logic                    last_served;
    logic                    dropped;
  } serve_t;

  class sstf_scoreboard;
    logic [PORT_TRACK_W-1:0] track_store [QUEUE_DEPTH];
    int unsigned             track_count = 0;
    bit                      overflow = 0;
    logic [PORT_TRACK_W-1:0] head_start = '0;
    serve_t                  pending_serves [$];
    int                      errors = 0;

    function void set_start(logic [PORT_TRACK_W-1:0] trk);
      head_start = trk;
    endfunction

    function int pending();
      return pending_serves.size();
    endfunction

    // take one request beat; on the last one, order the batch by shortest seek
    function void note_request(logic [PORT_TRACK_W-1:0] trk, logic lst);
      bit                      served [QUEUE_DEPTH];
      logic [PORT_TRACK_W-1:0] head;
      logic [SUM_W-1:0]        sum;
      logic [SEEK_W-1:0]       cand_dist;
      logic [SEEK_W-1:0]       best_dist;
      int                      best;
      serve_t                  s;
      if (track_count < QUEUE_DEPTH) begin
        track_store[track_count] = trk;
        track_count++;
      end else begin
        overflow = 1;
      end
      if (!lst) return;
      head = head_start;
      sum  = '0;
      for (int j = 0; j < QUEUE_DEPTH; j++) served[j] = 0;
      for (int r = 0; r < int'(track_count); r++) begin
        best      = -1;
        best_dist = '0;
        for (int j = 0; j < int'(track_count); j++) begin
          if (!served[j]) begin
            cand_dist = (head >= track_store[j]) ? head - track_store[j]
                                                 : track_store[j] - head;
            if (best < 0 || cand_dist < best_dist) begin
              best      = j;
              best_dist = cand_dist;
            end
          end
        end
        served[best]     = 1;
        head             = track_store[best];
        sum              = sum + SUM_W'(best_dist);
        s.served_track   = head;
        s.seek_distance  = best_dist;
        s.total_movement = sum[TOTAL_W-1:0];
        s.last_served    = (r + 1 == int'(track_count));
        s.dropped        = overflow;
        pending_serves.push_back(s);
      end
      track_count = 0;
      overflow    = 0;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(serve_t got);
      serve_t want;
      if (pending_serves.size() == 0) begin
        $display("%0t: unexpected result: expected none, got track %0d", $time,
                 got.served_track);
        errors++;
        return;
      end
      want = pending_serves.pop_front();
      compare_field("served_track", want.served_track, got.served_track);
      compare_field("seek_distance", want.seek_distance, got.seek_distance);
      compare_field("total_movement", want.total_movement, got.total_movement);
      compare_field("last_served", want.last_served, got.last_served);
      compare_field("dropped", want.dropped, got.dropped);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [PORT_TRACK_W-1:0] request_track = '0;
  logic                    last_request = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [PORT_TRACK_W-1:0] cfg_data = '0;
  logic                    result_valid;
  logic [PORT_TRACK_W-1:0] served_track;
  logic [SEEK_W-1:0]       seek_distance;
  logic [TOTAL_W-1:0]      total_movement;
  logic                    last_served;
  logic                    dropped;

  sstf_scoreboard          sb;
  int                      idle_pct = 0;
  int                      items_sent = 0;
  int                      quiet_cycles = 0;
  logic [PORT_TRACK_W-1:0] cur_start = '0;

  always #10 clk = ~clk;

  sstf_disk_scheduler #(
    .MAX_QUEUE(QUEUE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request_track(request_track),
    .last_request(last_request),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .served_track(served_track),
    .seek_distance(seek_distance),
    .total_movement(total_movement),
    .last_served(last_served),
    .dropped(dropped)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_start(cfg_data);
      if (start && !busy) sb.note_request(request_track, last_request);
      if (result_valid)
        sb.check_result({served_track, seek_distance, total_movement, last_served, dropped});
      if ((cfg_valid && cfg_ready) || (start && !busy) || result_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // all tasks start and end at a falling edge
  task automatic drive_request(input logic [PORT_TRACK_W-1:0] trk, input logic lst);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    request_track <= trk;
    last_request  <= lst;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_start(input logic [PORT_TRACK_W-1:0] trk);
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= trk;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_start = trk;
  endtask

  // flavor 0: full range, 1: clustered on the head (ties), 2: repeats from a pool
  task automatic run_batch(input int n, input int flavor);
    logic [PORT_TRACK_W-1:0] pool [4];
    logic [PORT_TRACK_W-1:0] trk;
    for (int i = 0; i < 4; i++) pool[i] = PORT_TRACK_W'($urandom_range(0, 65535));
    for (int i = 0; i < n; i++) begin
      case (flavor)
        0:       trk = PORT_TRACK_W'($urandom_range(0, 65535));
        1:       trk = cur_start + PORT_TRACK_W'($urandom_range(0, 16)) - PORT_TRACK_W'(8);
        default: trk = pool[$urandom_range(0, 3)];
      endcase
      drive_request(trk, i == n - 1);
      items_sent++;
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_start(16'd0);
    drive_request(16'd0, 1'b1);
    drive_request(16'hFFFF, 1'b1);
    write_start(16'hFFFF);
    drive_request(16'd0, 1'b0);
    drive_request(16'hAAAA, 1'b0);
    drive_request(16'h5555, 1'b0);
    drive_request(16'hFFFF, 1'b1);
    write_start(16'd1000);
    drive_request(16'd1010, 1'b0);
    drive_request(16'd990, 1'b0);
    drive_request(16'd1000, 1'b0);
    drive_request(16'd1000, 1'b1);
    drive_request(16'd1000, 1'b0);
    drive_request(16'd1000, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  write_start(16'd0);    end
        1:       begin idle_pct = 82; write_start(16'hFFFF); end
        2:       begin idle_pct = 0;  write_start(16'h8000); end
        default: begin idle_pct = 34; write_start(PORT_TRACK_W'($urandom_range(0, 65535))); end
      endcase
      items_sent = 0;
      if (ph == 1) run_batch(QUEUE_DEPTH, 0);
      if (ph == 3) run_batch(QUEUE_DEPTH + 3, 1);
      items_sent = 0;
      while (items_sent < 25) begin
        if ($urandom_range(0, 5) == 0) write_start(PORT_TRACK_W'($urandom_range(0, 65535)));
        run_batch($urandom_range(1, 10), $urandom_range(0, 2));
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sstf_pkg.sv
hw/rtl/sstf_ram.sv
hw/rtl/sstf_fifo.sv
hw/rtl/sstf_front.sv
hw/rtl/sstf_back.sv
hw/rtl/sstf_disk_scheduler.sv
tb/testbench.sv
